// ----- hdl/adc_to_temperature_interpolator_core_macros.svh -----
// Assertion macros for the ADC-to-temperature interpolator checker.
// Included by the checker file only; no other dependencies.
`ifndef ADC_TO_TEMPERATURE_INTERPOLATOR_CORE_MACROS_SVH
`define ADC_TO_TEMPERATURE_INTERPOLATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ADCTI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("adcti: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ADCTI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("adcti: next-cycle check failed");

`endif

// ----- hdl/adcti_pkg.sv -----
// Shared constants, calibration tables and types of the ADC-to-temperature interpolator.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package adcti_pkg;

	localparam int TABLE_POINTS = 53;
	localparam int SAMPLE_LIMIT = 1024;
	localparam int SAMPLE_W     = 10;
	localparam int ADC_W        = 11;
	localparam int TEMP_W       = 13;
	localparam int OFFSET_W     = 10;
	localparam int SEG_W        = $clog2(TABLE_POINTS);
	localparam int SEG_MAX      = TABLE_POINTS - 2;
	localparam int DT_W         = TEMP_W + 1;
	localparam int DS_W         = ADC_W + 1;
	localparam int PROD_W       = DT_W + DS_W;
	localparam int MAG_W        = PROD_W - 1;
	localparam int DEN_W        = ADC_W;
	localparam int SUM_W        = MAG_W + 2;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int APB_ADDR_W   = 3;
	localparam int APB_DATA_W   = 32;

	localparam logic [OFFSET_W-1:0]   OFFSET_RESET = 10'd200;
	localparam logic [APB_ADDR_W-1:0] ADDR_OFFSET  = 3'd0;

	localparam logic [ADC_W-1:0] ADC_ROM [TABLE_POINTS] = '{
		11'd0,    11'd8,    11'd6,    11'd21,   11'd37,   11'd53,   11'd69,   11'd85,
		11'd102,  11'd119,  11'd136,  11'd153,  11'd171,  11'd188,  11'd206,  11'd225,
		11'd243,  11'd262,  11'd281,  11'd300,  11'd319,  11'd339,  11'd359,  11'd379,
		11'd400,  11'd421,  11'd442,  11'd463,  11'd484,  11'd506,  11'd528,  11'd550,
		11'd573,  11'd596,  11'd619,  11'd642,  11'd666,  11'd689,  11'd713,  11'd738,
		11'd762,  11'd787,  11'd812,  11'd837,  11'd863,  11'd889,  11'd915,  11'd941,
		11'd967,  11'd994,  11'd1021, 11'd1023, 11'd1024
	};

	localparam logic [TEMP_W-1:0] TEMP_ROM [TABLE_POINTS] = '{
		13'd4000, 13'd4000, 13'd3960, 13'd3920, 13'd3880, 13'd3840, 13'd3800, 13'd3760,
		13'd3720, 13'd3680, 13'd3640, 13'd3600, 13'd3560, 13'd3520, 13'd3480, 13'd3440,
		13'd3400, 13'd3360, 13'd3320, 13'd3280, 13'd3240, 13'd3200, 13'd3160, 13'd3120,
		13'd3080, 13'd3040, 13'd3000, 13'd2960, 13'd2920, 13'd2880, 13'd2840, 13'd2800,
		13'd2760, 13'd2720, 13'd2680, 13'd2640, 13'd2600, 13'd2560, 13'd2520, 13'd2480,
		13'd2440, 13'd2400, 13'd2360, 13'd2320, 13'd2280, 13'd2240, 13'd2200, 13'd2160,
		13'd2120, 13'd2080, 13'd2040, 13'd2000, 13'd2000
	};

	// One classified sample: the sample and the table segment it falls in.
	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic [SEG_W-1:0]    seg;
	} seg_item_t;

	function automatic logic [ADC_W-1:0] adc_at(input logic [SEG_W-1:0] idx);
		logic [ADC_W-1:0] v;
		v = '0;
		if (32'(idx) < TABLE_POINTS) begin
			v = ADC_ROM[idx];
		end
		return v;
	endfunction

	function automatic logic [TEMP_W-1:0] temp_at(input logic [SEG_W-1:0] idx);
		logic [TEMP_W-1:0] v;
		v = '0;
		if (32'(idx) < TABLE_POINTS) begin
			v = TEMP_ROM[idx];
		end
		return v;
	endfunction

endpackage

// ----- hdl/adc_to_temperature_interpolator_core.sv -----
// Path of a sample: front register, queue, lookup, product, magnitude, divider, output.
// Throughput: one sample per cycle while result_stall is low; the 25-stage restoring divider
// in the back end is fully pipelined, so the combinational segment search sets the rate.
// Reset: arst_n clears all valid flags and queue pointers and sets the output offset to 200;
// there is no clearing pass, so samples are taken from the first cycle after reset.
`timescale 1ns / 1ps

module adc_to_temperature_interpolator_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [adcti_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [adcti_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [adcti_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                pready,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  logic [adcti_pkg::SAMPLE_W-1:0]      adc_sample,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [adcti_pkg::TEMP_W-1:0]        temperature
);

	logic [adcti_pkg::OFFSET_W-1:0] offset;
	logic                           push_valid;
	logic                           push_stall;
	adcti_pkg::seg_item_t           push_item;
	logic                           head_valid;
	logic                           head_stall;
	adcti_pkg::seg_item_t           head_item;

	adcti_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.offset  (offset)
	);

	adcti_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.adc_sample   (adc_sample),
		.push_valid   (push_valid),
		.push_stall   (push_stall),
		.push_item    (push_item)
	);

	adcti_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_stall (push_stall),
		.push_item  (push_item),
		.pop_valid  (head_valid),
		.pop_stall  (head_stall),
		.pop_item   (head_item)
	);

	adcti_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.offset       (offset),
		.head_valid   (head_valid),
		.head_stall   (head_stall),
		.head_item    (head_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.temperature  (temperature)
	);

endmodule

// ----- hdl/adcti_regs.sv -----
// Configuration register file of the interpolator: the output offset behind an APB-style port.
// Depends on adcti_pkg.
`timescale 1ns / 1ps

module adcti_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [adcti_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [adcti_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [adcti_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                pready,
	output logic [adcti_pkg::OFFSET_W-1:0]      offset
);

	logic [adcti_pkg::OFFSET_W-1:0] offset_q;
	logic                           wr_offset;

	assign pready    = 1'b1;
	assign wr_offset = psel && penable && pwrite && (paddr == adcti_pkg::ADDR_OFFSET);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= adcti_pkg::OFFSET_RESET;
		end else if (wr_offset) begin
			offset_q <= pwdata[adcti_pkg::OFFSET_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == adcti_pkg::ADDR_OFFSET) begin
			prdata = {{(adcti_pkg::APB_DATA_W - adcti_pkg::OFFSET_W){1'b0}}, offset_q};
		end
	end

	assign offset = offset_q;

endmodule

// ----- hdl/adcti_front.sv -----
// Front end: accepts ADC samples and finds the calibration segment each one falls in.
// Depends on adcti_pkg.
`timescale 1ns / 1ps

module adcti_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               sample_valid,
	output logic                               sample_stall,
	input  logic [adcti_pkg::SAMPLE_W-1:0]     adc_sample,
	output logic                               push_valid,
	input  logic                               push_stall,
	output adcti_pkg::seg_item_t               push_item
);

	logic                              valid_s1;
	adcti_pkg::seg_item_t              item_s1;
	logic [adcti_pkg::SAMPLE_W-1:0]    smp_c;
	logic [adcti_pkg::SEG_W-1:0]       seg_c;
	logic                              accept;
	logic                              push;

	assign push         = valid_s1 && !push_stall;
	assign sample_stall = valid_s1 && push_stall;
	assign accept       = sample_valid && !sample_stall;

	// The segment is the last table entry whose converter value lies strictly below
	// the sample; the table is not monotonic at its low end, so every entry is checked.
	always_comb begin
		smp_c = adc_sample;
		if (32'(adc_sample) > adcti_pkg::SAMPLE_LIMIT - 1) begin
			smp_c = adcti_pkg::SAMPLE_W'(adcti_pkg::SAMPLE_LIMIT - 1);
		end
		seg_c = '0;
		for (int k = 0; k < adcti_pkg::TABLE_POINTS; k++) begin
			if (adcti_pkg::ADC_ROM[k] < {1'b0, smp_c}) begin
				seg_c = adcti_pkg::SEG_W'(k);
			end
		end
		if (seg_c > adcti_pkg::SEG_W'(adcti_pkg::SEG_MAX)) begin
			seg_c = adcti_pkg::SEG_W'(adcti_pkg::SEG_MAX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.sample <= smp_c;
			item_s1.seg    <= seg_c;
		end
	end

	assign push_valid = valid_s1;
	assign push_item  = item_s1;

endmodule

// ----- hdl/adcti_queue.sv -----
// Short queue of classified samples between the front end and the interpolation pipeline.
// Depends on adcti_pkg.
`timescale 1ns / 1ps

module adcti_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	output logic                  push_stall,
	input  adcti_pkg::seg_item_t  push_item,
	output logic                  pop_valid,
	input  logic                  pop_stall,
	output adcti_pkg::seg_item_t  pop_item
);

	adcti_pkg::seg_item_t             entry_q [adcti_pkg::QUEUE_DEPTH];
	logic [adcti_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [adcti_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [adcti_pkg::QCNT_W-1:0]     count_q;
	logic                             push;
	logic                             pop;

	assign push_stall = (count_q == adcti_pkg::QCNT_W'(adcti_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && !push_stall;
	assign pop        = pop_valid && !pop_stall;
	assign pop_item   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == adcti_pkg::QUEUE_DEPTH - 1) ? '0
					: wr_ptr_q + adcti_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == adcti_pkg::QUEUE_DEPTH - 1) ? '0
					: rd_ptr_q + adcti_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + adcti_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - adcti_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ----- hdl/adcti_back.sv -----
// Back end: table lookup, slope multiply, pipelined restoring divide, offset add and the
// output register. Depends on adcti_pkg.
`timescale 1ns / 1ps

module adcti_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [adcti_pkg::OFFSET_W-1:0]    offset,
	input  logic                              head_valid,
	output logic                              head_stall,
	input  adcti_pkg::seg_item_t              head_item,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [adcti_pkg::TEMP_W-1:0]      temperature
);

	localparam int MAG_W  = adcti_pkg::MAG_W;
	localparam int DEN_W  = adcti_pkg::DEN_W;
	localparam int TEMP_W = adcti_pkg::TEMP_W;
	localparam int SUM_W  = adcti_pkg::SUM_W;

	typedef struct packed {
		logic [DEN_W-1:0]  rem;
		logic [MAG_W-1:0]  dvd;
		logic [MAG_W-1:0]  quo;
		logic [DEN_W-1:0]  den;
		logic [TEMP_W-1:0] t0;
		logic              hit;
		logic              neg;
	} div_word_t;

	// One restoring step: bring in the next dividend bit and subtract the divisor if it fits.
	function automatic div_word_t div_step(input div_word_t w);
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		logic           fits;
		div_word_t      r;
		trial = {w.rem, w.dvd[MAG_W-1]};
		diff  = trial - {1'b0, w.den};
		fits  = (trial >= {1'b0, w.den});
		r     = w;
		r.rem = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		r.dvd = {w.dvd[MAG_W-2:0], 1'b0};
		r.quo = {w.quo[MAG_W-2:0], fits};
		return r;
	endfunction

	logic                                   adv;
	logic                                   pop;

	// Stage 1: table lookup and differences.
	logic                                   valid_s1;
	logic signed [adcti_pkg::DT_W-1:0]      dt_s1;
	logic signed [adcti_pkg::DS_W-1:0]      ds_s1;
	logic [DEN_W-1:0]                       den_s1;
	logic [TEMP_W-1:0]                      t0_s1;
	logic                                   hit_s1;

	// Stage 2: product.
	logic                                   valid_s2;
	logic signed [adcti_pkg::PROD_W-1:0]    prod_s2;
	logic [DEN_W-1:0]                       den_s2;
	logic [TEMP_W-1:0]                      t0_s2;
	logic                                   hit_s2;

	// Divider pipeline: index k holds stage 3+k; index 0 is the magnitude stage.
	logic [MAG_W:0]                         valid_s3;
	div_word_t                              div_s3 [MAG_W+1];

	logic [adcti_pkg::ADC_W-1:0]            a0_c;
	logic [adcti_pkg::ADC_W-1:0]            a1_c;
	logic [TEMP_W-1:0]                      t1_c;
	logic [TEMP_W-1:0]                      t0_c;
	logic [adcti_pkg::ADC_W-1:0]            s_c;
	logic                                   hit_c;
	logic [adcti_pkg::PROD_W-1:0]           abs_c;
	logic signed [SUM_W-1:0]                qs_c;
	logic signed [SUM_W-1:0]                sum_c;
	logic [TEMP_W-1:0]                      temp_c;

	logic                                   result_valid_q;
	logic [TEMP_W-1:0]                      temperature_q;

	// The whole pipeline moves together whenever the output register can take a result.
	assign adv        = !result_valid_q || !result_stall;
	assign pop        = head_valid && adv;
	assign head_stall = !adv;

	always_comb begin
		s_c   = {1'b0, head_item.sample};
		a0_c  = adcti_pkg::adc_at(head_item.seg);
		a1_c  = adcti_pkg::adc_at(head_item.seg + adcti_pkg::SEG_W'(1));
		t0_c  = adcti_pkg::temp_at(head_item.seg);
		t1_c  = adcti_pkg::temp_at(head_item.seg + adcti_pkg::SEG_W'(1));
		// An exact hit or a flat or falling segment returns the lower entry unchanged.
		hit_c = (a0_c == s_c) || (a1_c <= a0_c);
	end

	always_comb begin
		abs_c = prod_s2[adcti_pkg::PROD_W-1] ? (-prod_s2) : prod_s2;
	end

	always_comb begin
		qs_c = $signed({2'b00, div_s3[MAG_W].quo});
		if (div_s3[MAG_W].neg) begin
			qs_c = -qs_c;
		end
		if (div_s3[MAG_W].hit) begin
			qs_c = '0;
		end
		sum_c = $signed({{(SUM_W - TEMP_W){1'b0}}, div_s3[MAG_W].t0}) + qs_c
			+ $signed({{(SUM_W - adcti_pkg::OFFSET_W){1'b0}}, offset});
		temp_c = sum_c[SUM_W-1] ? '0 : sum_c[TEMP_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			valid_s3       <= '0;
			result_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1       <= pop;
			valid_s2       <= valid_s1;
			valid_s3       <= {valid_s3[MAG_W-1:0], valid_s2};
			result_valid_q <= valid_s3[MAG_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dt_s1  <= $signed({1'b0, t1_c}) - $signed({1'b0, t0_c});
			ds_s1  <= $signed({1'b0, s_c}) - $signed({1'b0, a0_c});
			den_s1 <= hit_c ? DEN_W'(1) : (a1_c - a0_c);
			t0_s1  <= t0_c;
			hit_s1 <= hit_c;

			prod_s2 <= $signed({{adcti_pkg::DS_W{dt_s1[adcti_pkg::DT_W-1]}}, dt_s1})
				* $signed({{adcti_pkg::DT_W{ds_s1[adcti_pkg::DS_W-1]}}, ds_s1});
			den_s2  <= den_s1;
			t0_s2   <= t0_s1;
			hit_s2  <= hit_s1;

			div_s3[0].rem <= '0;
			div_s3[0].dvd <= abs_c[MAG_W-1:0];
			div_s3[0].quo <= '0;
			div_s3[0].den <= den_s2;
			div_s3[0].t0  <= t0_s2;
			div_s3[0].hit <= hit_s2;
			div_s3[0].neg <= prod_s2[adcti_pkg::PROD_W-1];

			temperature_q <= temp_c;
		end
	end

	for (genvar k = 1; k <= MAG_W; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (adv) begin
				div_s3[k] <= div_step(div_s3[k-1]);
			end
		end
	end

	assign result_valid = result_valid_q;
	assign temperature  = temperature_q;

endmodule

// ----- hdl/adcti_checker.sv -----
// Port-level checker for the interpolator core, bound to the top level.
// Depends on adcti_pkg and adc_to_temperature_interpolator_core_macros.svh.
`timescale 1ns / 1ps
`include "adc_to_temperature_interpolator_core_macros.svh"

module adcti_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic                                pready,
	input  logic [adcti_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [adcti_pkg::APB_DATA_W-1:0]    pwdata,
	input  logic [adcti_pkg::APB_DATA_W-1:0]    prdata,
	input  logic                                result_valid,
	input  logic                                result_stall,
	input  logic [adcti_pkg::TEMP_W-1:0]        temperature
);

	logic                             offset_write;
	logic                             offset_sel;
	logic [adcti_pkg::OFFSET_W-1:0]   written_q;
	logic [adcti_pkg::APB_DATA_W-1:0] offset_echo;

	assign offset_sel   = (paddr == adcti_pkg::ADDR_OFFSET);
	assign offset_write = psel && penable && pwrite && pready && offset_sel;
	assign offset_echo  = adcti_pkg::APB_DATA_W'(written_q);

	// Low bits of pwdata, registered every cycle for comparison with the register in the next cycle.
	always_ff @(posedge clk) begin
		written_q <= pwdata[adcti_pkg::OFFSET_W-1:0];
	end

	// A stalled result transaction stays offered.
	`ADCTI_ASSERT_NEXT(a_result_held, clk, arst_n, result_valid && result_stall, result_valid)

	// A stalled result transaction keeps its temperature.
	`ADCTI_ASSERT_NEXT(a_result_stable, clk, arst_n, result_valid && result_stall, $stable(temperature))

	// Table span plus the largest offset bounds every temperature.
	`ADCTI_ASSERT_NOW(a_temp_range, clk, arst_n, result_valid, temperature <= 13'd5023)

	// A write to the offset register reads back on the following cycle.
	`ADCTI_ASSERT_NEXT(a_offset_readback, clk, arst_n, offset_write, !offset_sel || prdata == offset_echo)

endmodule

bind adc_to_temperature_interpolator_core adcti_checker u_adcti_checker (.*);
